/* src/periodic_task_release_timer_assert.svh */
// Assertion macros for the periodic task release timer.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef PERIODIC_TASK_RELEASE_TIMER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_TIMER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PTRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PTRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ptrt_pkg.sv */
// Shared types and constants for the periodic task release timer.
// No dependencies; used by ptrt_count_unit and the top level.
package ptrt_pkg;

	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 2;
	localparam int ENTRY_W    = 16;
	localparam int TABLE_W    = 64;
	localparam int TICK_W     = 10;
	localparam int OPCODE_W   = 3;
	localparam int INDEX_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INIT    = 3'd0,
		OP_TICK    = 3'd1,
		OP_SUSPEND = 3'd2,
		OP_RESUME  = 3'd3,
		OP_DELETE  = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD      = 3'd0,
		CFG_FIRST_DELAY = 3'd1,
		CFG_PRESENT     = 3'd2,
		CFG_START_RUN   = 3'd3,
		CFG_TICK        = 3'd4
	} cfg_reg_t;

	// Control from the sequencer to the shared count unit
	typedef struct packed {
		logic load_init;
		logic tick;
		logic eligible;
	} cu_ctrl_t;

endpackage

/* src/ptrt_count_unit.sv */
// Shared countdown unit: one task's next countdown value and release bit.
// Depends on ptrt_pkg.
module ptrt_count_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  ptrt_pkg::cu_ctrl_t           ctrl,
	input  logic [COUNT_WIDTH-1:0]       count,
	input  logic [ptrt_pkg::TICK_W-1:0]  tick_ms,
	input  logic [COUNT_WIDTH-1:0]       period,
	input  logic [COUNT_WIDTH-1:0]       first_delay,
	output logic [COUNT_WIDTH-1:0]       next_count,
	output logic                         fire
);
	import ptrt_pkg::*;

	localparam int DW = ((COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W) + 1;

	logic [DW-1:0] diff;
	logic          above;

	assign diff  = DW'(count) - DW'(tick_ms);
	// count > tick_ms exactly when the difference is positive
	assign above = !diff[DW-1] && (diff != '0);
	assign fire  = ctrl.tick && ctrl.eligible && (count == '0);

	always_comb begin
		if (ctrl.load_init) begin
			next_count = first_delay;
		end else if (fire) begin
			next_count = period;
		end else if (above) begin
			next_count = diff[COUNT_WIDTH-1:0];
		end else begin
			next_count = '0;
		end
	end

endmodule

/* src/periodic_task_release_timer.sv */
// Periodic task release timer: one countdown per task, visited in turn by a shared unit.
// Init and tick step the shared unit through every task before raising m_tvalid;
// suspend, resume, delete and unknown opcodes take a single step. The final step
// waits for any output stall. No new item is accepted until the current one is done,
// since the single count unit steps through the tasks one at a time.
// Reset: countdowns zero, all tasks running, none present, registers at reset values.
`include "periodic_task_release_timer_assert.svh"

module periodic_task_release_timer #(
	parameter int TASK_COUNT  = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [3:0] task_index
	input  logic [2:0]                       s_tuser,   // [2:0] opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [3:0] fire_mask
	output logic [0:0]                       m_tuser,   // [0] status
	input  logic                             cfg_we,
	input  logic [ptrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ptrt_pkg::*;

	localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam logic [IDX_W-1:0]   LAST_STEP = IDX_W'(TASK_COUNT - 1);
	localparam logic [INDEX_W-1:0] TASKS_IDX = INDEX_W'(TASK_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        step_q;
	logic [OPCODE_W-1:0]     op_q;
	logic [INDEX_W-1:0]      idx_q;
	logic [SLOTS-1:0]        fire_q;
	logic                    m_valid_q;
	logic [SLOTS-1:0]        m_fire_q;
	logic                    m_status_q;

	logic [TABLE_W-1:0]      period_q;
	logic [TABLE_W-1:0]      first_delay_q;
	logic [SLOTS-1:0]        present_mask_q;
	logic [SLOTS-1:0]        start_run_q;
	logic [TICK_W-1:0]       tick_q;

	logic [COUNT_WIDTH-1:0]  cnt_q [TASK_COUNT];
	logic [SLOTS-1:0]        running_q;
	logic [SLOTS-1:0]        present_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    multi;
	logic                    last;
	logic                    advance;
	logic                    commit;
	logic                    idx_ok;
	logic [SLOT_W-1:0]       fsel;
	logic [SLOT_W-1:0]       isel;
	logic [SLOTS-1:0]        fire_cur;
	logic                    status_cur;
	cu_ctrl_t                cu_ctrl;
	logic [COUNT_WIDTH-1:0]  cu_next;
	logic                    cu_fire;
	logic [COUNT_WIDTH-1:0]  period_e;
	logic [COUNT_WIDTH-1:0]  delay_e;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign multi    = (op_q == OP_INIT) || (op_q == OP_TICK);
	assign last     = !multi || (step_q == LAST_STEP);
	// Hold the final step until the output register can take the result
	assign advance  = (state_q == ST_WORK) && (!last || out_free);
	assign commit   = advance && last;

	assign fsel     = SLOT_W'(step_q);
	assign isel     = idx_q[SLOT_W-1:0];
	assign idx_ok   = (idx_q < TASKS_IDX) && present_q[isel];
	assign period_e = period_q[ENTRY_W*int'(step_q) +: COUNT_WIDTH];
	assign delay_e  = first_delay_q[ENTRY_W*int'(step_q) +: COUNT_WIDTH];

	assign cu_ctrl.load_init = (op_q == OP_INIT);
	assign cu_ctrl.tick      = (op_q == OP_TICK);
	assign cu_ctrl.eligible  = present_q[fsel] && running_q[fsel];

	ptrt_count_unit #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_count (
		.ctrl        (cu_ctrl),
		.count       (cnt_q[step_q]),
		.tick_ms     (tick_q),
		.period      (period_e),
		.first_delay (delay_e),
		.next_count  (cu_next),
		.fire        (cu_fire)
	);

	always_comb begin
		fire_cur = fire_q;
		fire_cur[fsel] = fire_q[fsel] | cu_fire;
	end

	always_comb begin
		case (op_q)
			OP_INIT, OP_TICK: status_cur = 1'b0;
			OP_SUSPEND, OP_RESUME, OP_DELETE: status_cur = !idx_ok;
			default: status_cur = 1'b1;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q       <= '0;
			first_delay_q  <= '0;
			present_mask_q <= '0;
			start_run_q    <= '1;
			tick_q         <= TICK_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD:      period_q       <= cfg_data;
				CFG_FIRST_DELAY: first_delay_q  <= cfg_data;
				CFG_PRESENT:     present_mask_q <= cfg_data[SLOTS-1:0];
				CFG_START_RUN:   start_run_q    <= cfg_data[SLOTS-1:0];
				CFG_TICK:        tick_q         <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= ST_WORK;
				step_q  <= '0;
			end else if (commit) begin
				state_q <= ST_IDLE;
			end else if (advance) begin
				step_q <= step_q + IDX_W'(1);
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Task state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
			running_q <= '1;
			present_q <= '0;
		end else if (advance) begin
			case (op_q)
				OP_INIT: begin
					cnt_q[step_q] <= cu_next;
					if (last) begin
						running_q <= start_run_q;
						present_q <= present_mask_q;
					end
				end
				OP_TICK: cnt_q[step_q] <= cu_next;
				OP_SUSPEND: if (idx_ok) running_q[isel] <= 1'b0;
				OP_RESUME:  if (idx_ok) running_q[isel] <= 1'b1;
				OP_DELETE:  if (idx_ok) present_q[isel] <= 1'b0;
				default: ;
			endcase
		end
	end

	// Transaction payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_tuser[OPCODE_W-1:0];
			idx_q  <= s_tdata[INDEX_W-1:0];
			fire_q <= '0;
		end else if (advance) begin
			fire_q <= fire_cur;
		end
		if (commit) begin
			m_fire_q   <= fire_cur;
			m_status_q <= status_cur;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(8 - SLOTS)'(0), m_fire_q};
	assign m_tuser  = m_status_q;

	`PTRT_ASSERT_IMP(a_busy_not_ready, state_q == ST_WORK, !s_tready,
		"input ready while an item is in progress")
	`PTRT_ASSERT_NXT(a_accept_starts, in_acc, state_q == ST_WORK && step_q == '0,
		"accepted transaction did not start at the first task")
	`PTRT_ASSERT_IMP(a_step_range, state_q == ST_WORK, step_q <= LAST_STEP,
		"task step beyond task count")
	`PTRT_ASSERT_NXT(a_fire_only_tick, commit && op_q != OP_TICK, m_tdata[SLOTS-1:0] == '0,
		"release mask set for a non-tick opcode")
	`PTRT_ASSERT_NXT(a_init_tick_ok, commit && multi, m_tuser == 1'b0 && m_tvalid,
		"init or tick reported rejected")

endmodule
